@@ hdl/generational_handle_pool_assert.svh @@
// assertion macros for the generational handle pool
// used by the top level only, no other dependencies
`ifndef GENERATIONAL_HANDLE_POOL_ASSERT_SVH
`define GENERATIONAL_HANDLE_POOL_ASSERT_SVH

`ifndef SYNTH
// condition in this cycle implies a consequence in the same cycle
`define GHP_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("handle pool check failed");
// condition in this cycle implies a consequence in the next cycle
`define GHP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("handle pool check failed");
`else
`define GHP_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define GHP_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

@@ hdl/ghp_pkg.sv @@
// shared types and constants of the generational handle pool
// no dependencies
package ghp_pkg;

    // parameter defaults
    localparam int DEF_POOL_SLOTS = 16;
    localparam int DEF_OWNER_BITS = 16;

    // field widths fixed by the interface
    localparam int SLOT_FIELD_W  = 8;
    localparam int GEN_W         = 32;
    localparam int OWNER_FIELD_W = 16;
    localparam int TDATA_W       = 64;
    localparam int IN_TUSER_W    = 2;

    // generation of a slot that was never released
    localparam logic [GEN_W-1:0] FIRST_GEN = 32'd1;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_RELEASE = 2'd1,
        OP_VIEW    = 2'd2
    } op_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic resolve;
        logic fetch;
        logic commit;
    } ghp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_stall;
    } ghp_status_t;

endpackage

@@ hdl/ghp_ctrl.sv @@
// controller state machine of the generational handle pool
// depends on ghp_pkg for the command and status types
module ghp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  ghp_pkg::ghp_status_t status,
    output ghp_pkg::ghp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_RESOLVE = 4'b0010,
        ST_FETCH   = 4'b0100,
        ST_COMMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: state_next = ST_FETCH;
            ST_FETCH:   state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (!status.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands to the datapath
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cmd.capture   = (state_reg == ST_IDLE) && s_axis_tvalid;
    assign cmd.resolve   = (state_reg == ST_RESOLVE);
    assign cmd.fetch     = (state_reg == ST_FETCH);
    assign cmd.commit    = (state_reg == ST_COMMIT) && !status.out_stall;

endmodule

@@ hdl/ghp_datapath.sv @@
// datapath of the generational handle pool: occupancy, slot stores, checks
// and the output register; depends on ghp_pkg
module ghp_datapath #(
    parameter int POOL_SLOTS = ghp_pkg::DEF_POOL_SLOTS,
    parameter int OWNER_BITS = ghp_pkg::DEF_OWNER_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ghp_pkg::ghp_cmd_t                cmd,
    output ghp_pkg::ghp_status_t             status,
    input  logic [ghp_pkg::TDATA_W-1:0]      s_axis_tdata,
    input  logic [ghp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ghp_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tuser
);

    localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int OWN_W  = (OWNER_BITS < ghp_pkg::OWNER_FIELD_W) ?
                            OWNER_BITS : ghp_pkg::OWNER_FIELD_W;
    localparam int GEN_W  = ghp_pkg::GEN_W;
    localparam int SF_W   = ghp_pkg::SLOT_FIELD_W;
    localparam int OF_W   = ghp_pkg::OWNER_FIELD_W;

    // captured input item
    ghp_pkg::op_t      op_reg;
    logic [SF_W-1:0]   hslot_reg;
    logic [GEN_W-1:0]  hgen_reg;
    logic [OWN_W-1:0]  owner_reg;
    logic              priv_reg;

    // resolved slot
    logic [SLOT_W-1:0] addr_reg;
    logic              in_range_reg;
    logic              free_found_reg;

    // slot state
    logic [POOL_SLOTS-1:0] occ_reg;
    logic [POOL_SLOTS-1:0] occ_next;
    logic [POOL_SLOTS-1:0] gen_set_reg;
    logic [POOL_SLOTS-1:0] gen_set_next;
    logic [GEN_W-1:0]      gen_mem [POOL_SLOTS];
    logic [OWN_W-1:0]      owner_mem [POOL_SLOTS];
    logic                  priv_mem [POOL_SLOTS];

    // read data
    logic [GEN_W-1:0]  gen_rd_reg;
    logic [OWN_W-1:0]  owner_rd_reg;
    logic              priv_rd_reg;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_ok_reg;
    logic [SF_W-1:0]   out_slot_reg;
    logic [GEN_W-1:0]  out_gen_reg;
    logic [OF_W-1:0]   out_owner_reg;
    logic              out_priv_reg;

    // combinational results
    logic              ff_found;
    logic [SLOT_W-1:0] ff_idx;
    logic              hs_in_range;
    logic [GEN_W-1:0]  gen_cur;
    logic              handle_ok;
    logic              ok_c;
    logic [SF_W-1:0]   slot_c;
    logic [GEN_W-1:0]  gen_c;
    logic [OF_W-1:0]   owner_c;
    logic              priv_c;
    logic              do_create;
    logic              do_release;

    // capture the input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= ghp_pkg::op_t'(s_axis_tuser);
            hslot_reg <= s_axis_tdata[SF_W-1:0];
            hgen_reg  <= s_axis_tdata[SF_W+GEN_W-1:SF_W];
            owner_reg <= s_axis_tdata[SF_W+GEN_W+OWN_W-1:SF_W+GEN_W];
            priv_reg  <= s_axis_tdata[SF_W+GEN_W+OF_W];
        end
    end

    // lowest free slot
    always_comb
    begin
        ff_found = 1'b0;
        ff_idx   = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                ff_found = 1'b1;
                ff_idx   = SLOT_W'(i);
            end
        end
    end

    assign hs_in_range = ({1'b0, hslot_reg} < (SF_W + 1)'(POOL_SLOTS));

    // resolve the slot address
    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            in_range_reg   <= hs_in_range;
            free_found_reg <= ff_found;
            if (op_reg == ghp_pkg::OP_CREATE)
            begin
                addr_reg <= ff_idx;
            end
            else if (hs_in_range)
            begin
                addr_reg <= hslot_reg[SLOT_W-1:0];
            end
            else
            begin
                addr_reg <= '0;
            end
        end
    end

    // slot store reads and writes
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            gen_rd_reg   <= gen_mem[addr_reg];
            owner_rd_reg <= owner_mem[addr_reg];
            priv_rd_reg  <= priv_mem[addr_reg];
        end
        if (do_release)
        begin
            gen_mem[addr_reg] <= gen_cur + GEN_W'(1);
        end
        if (do_create)
        begin
            owner_mem[addr_reg] <= owner_reg;
            priv_mem[addr_reg]  <= priv_reg;
        end
    end

    // handle check and result
    assign gen_cur   = gen_set_reg[addr_reg] ? gen_rd_reg : ghp_pkg::FIRST_GEN;
    assign handle_ok = in_range_reg && occ_reg[addr_reg] && (gen_cur == hgen_reg);

    always_comb
    begin
        ok_c       = 1'b0;
        slot_c     = '0;
        gen_c      = '0;
        owner_c    = '0;
        priv_c     = 1'b0;
        do_create  = 1'b0;
        do_release = 1'b0;
        case (op_reg)
            ghp_pkg::OP_CREATE:
            begin
                ok_c      = free_found_reg;
                do_create = cmd.commit && free_found_reg;
                if (free_found_reg)
                begin
                    slot_c = SF_W'(addr_reg);
                    gen_c  = gen_cur;
                end
            end
            ghp_pkg::OP_RELEASE:
            begin
                ok_c       = handle_ok;
                do_release = cmd.commit && handle_ok;
            end
            ghp_pkg::OP_VIEW:
            begin
                ok_c = handle_ok;
                if (handle_ok)
                begin
                    owner_c = OF_W'(owner_rd_reg);
                    priv_c  = priv_rd_reg;
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    // occupancy and generation-written bits
    always_comb
    begin
        occ_next     = occ_reg;
        gen_set_next = gen_set_reg;
        if (do_create)
        begin
            occ_next[addr_reg] = 1'b1;
        end
        if (do_release)
        begin
            occ_next[addr_reg]     = 1'b0;
            gen_set_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            gen_set_reg <= '0;
        end
        else
        begin
            occ_reg     <= occ_next;
            gen_set_reg <= gen_set_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_ok_reg    <= ok_c;
            out_slot_reg  <= slot_c;
            out_gen_reg   <= gen_c;
            out_owner_reg <= owner_c;
            out_priv_reg  <= priv_c;
        end
    end

    assign status.out_stall = out_valid_reg && !m_axis_tready;
    assign m_axis_tvalid    = out_valid_reg;
    assign m_axis_tuser     = out_ok_reg;
    assign m_axis_tdata     = {{(ghp_pkg::TDATA_W - SF_W - GEN_W - OF_W - 1){1'b0}},
                               out_priv_reg, out_owner_reg, out_gen_reg, out_slot_reg};

endmodule

@@ hdl/generational_handle_pool.sv @@
// generational handle pool, top level: controller plus datapath
// an item is accepted in idle, then passes resolve, fetch and commit; the result
// is written to the output register at commit, which waits while the output stalls
// a new item is taken only in idle, once the last one has left commit
// a finished result waits in the output register while the next item enters
// reset clears occupancy and generation-written flags at once, no clear pass
`include "generational_handle_pool_assert.svh"

module generational_handle_pool #(
    parameter int POOL_SLOTS = ghp_pkg::DEF_POOL_SLOTS,
    parameter int OWNER_BITS = ghp_pkg::DEF_OWNER_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // handle_slot[7:0], handle_generation[39:8], owner_id[55:40],
    // is_privileged[56], zero fill
    input  logic [ghp_pkg::TDATA_W-1:0]      s_axis_tdata,
    // operation[1:0]
    input  logic [ghp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_slot[7:0], result_generation[39:8], result_owner[55:40],
    // result_privileged[56], zero fill
    output logic [ghp_pkg::TDATA_W-1:0]      m_axis_tdata,
    // ok[0]
    output logic                             m_axis_tuser
);

    ghp_pkg::ghp_cmd_t    cmd;
    ghp_pkg::ghp_status_t status;

    // sequencing
    ghp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // slot state and result
    ghp_datapath #(
        .POOL_SLOTS (POOL_SLOTS),
        .OWNER_BITS (OWNER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // checks
    `GHP_ASSERT_SAME(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
    `GHP_ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `GHP_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, m_axis_tvalid)

endmodule

@@ tb/tb_generational_handle_pool.sv @@
// self-checking testbench for the generational handle pool: directed and random
// create, release and view requests, checked against a shadow model of the slots
// depends on ghp_pkg and the generational_handle_pool top level
module tb_generational_handle_pool;

    localparam int         SLOTS        = ghp_pkg::DEF_POOL_SLOTS;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1100;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 12;

    // one result as the block should return it
    typedef struct {
        bit        ok;
        bit [7:0]  slot;
        bit [31:0] gen;
        bit [15:0] owner;
        bit        priv;
    } reply_t;

    // shadow copy of the slot table plus the replies still owed by the block
    class handle_pool_shadow;
        bit        occupied   [SLOTS];
        bit [31:0] generation [SLOTS];
        bit [15:0] owner      [SLOTS];
        bit        privileged [SLOTS];
        reply_t    pending_replies [$];
        int        errors;
        int        replies;
        int        n_created, n_full, n_released, n_viewed, n_rejected, n_unused;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                occupied[i]   = 1'b0;
                generation[i] = ghp_pkg::FIRST_GEN;
                owner[i]      = '0;
                privileged[i] = 1'b0;
            end
        endfunction

        task report(string what);
            $display("mismatch at result %0d: %s", replies, what);
            errors++;
        endtask

        // accepted request: update the slots and queue the reply it earns
        function void apply_request(logic [1:0] op_code, bit [7:0] slot, bit [31:0] gen,
                                    bit [15:0] own, bit priv);
            reply_t r;
            bit     found;
            bit     handle_good;
            int     idx;
            r = '{default: 0};
            found = 1'b0;
            idx = int'(slot);
            handle_good = (idx < SLOTS) ? (occupied[idx] && generation[idx] == gen) : 1'b0;
            case (op_code)
                ghp_pkg::OP_CREATE:
                begin
                    // lowest free slot wins
                    for (int i = 0; i < SLOTS && !found; i++)
                    begin
                        if (!occupied[i])
                        begin
                            found         = 1'b1;
                            occupied[i]   = 1'b1;
                            owner[i]      = own;
                            privileged[i] = priv;
                            r.ok          = 1'b1;
                            r.slot        = 8'(i);
                            r.gen         = generation[i];
                        end
                    end
                    if (found)
                        n_created++;
                    else
                        n_full++;
                end
                ghp_pkg::OP_RELEASE:
                begin
                    if (handle_good)
                    begin
                        occupied[idx]   = 1'b0;
                        generation[idx] = generation[idx] + 32'd1;
                        r.ok            = 1'b1;
                        n_released++;
                    end
                    else
                        n_rejected++;
                end
                ghp_pkg::OP_VIEW:
                begin
                    if (handle_good)
                    begin
                        r.ok    = 1'b1;
                        r.owner = owner[idx];
                        r.priv  = privileged[idx];
                        n_viewed++;
                    end
                    else
                        n_rejected++;
                end
                default:
                    n_unused++;
            endcase
            pending_replies.insert(pending_replies.size(), r);
        endfunction

        // accepted result: compare with the oldest owed reply
        task check_reply(bit ok, bit [ghp_pkg::TDATA_W-1:0] data);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            want = pending_replies.pop_front();
            if (ok != want.ok)
                report($sformatf("ok %0d, want %0d", ok, want.ok));
            if (data[7:0] != want.slot)
                report($sformatf("slot %0d, want %0d", data[7:0], want.slot));
            if (data[39:8] != want.gen)
                report($sformatf("generation %h, want %h", data[39:8], want.gen));
            if (data[55:40] != want.owner)
                report($sformatf("owner %h, want %h", data[55:40], want.owner));
            if (data[56] != want.priv)
                report($sformatf("privileged %0d, want %0d", data[56], want.priv));
            if (data[63:57] != '0)
                report($sformatf("fill bits %h not zero", data[63:57]));
            replies++;
        endtask
    endclass

    logic                               clk;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ghp_pkg::TDATA_W-1:0]        s_axis_tdata  = '0;
    logic [ghp_pkg::IN_TUSER_W-1:0]     s_axis_tuser  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [ghp_pkg::TDATA_W-1:0]        m_axis_tdata;
    logic                               m_axis_tuser;

    handle_pool_shadow pool = new();
    bit                pace_gaps = 1'b1;

    generational_handle_pool dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one request transfer, after a random gap while gaps are paced
    task send_item(input logic [1:0] op_code, input bit [7:0] slot, input bit [31:0] gen,
                   input bit [15:0] own, input bit priv);
        int gap;
        gap = pace_gaps ? int'($urandom_range(0, 4)) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op_code;
        s_axis_tdata  <= {7'd0, priv, own, gen, slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pool.apply_request(op_code, slot, gen, own, priv);
    endtask

    // mostly good handles of live slots, with stale, foreign and noise requests mixed in
    task random_item(input int create_pct);
        int         pick;
        int         kind;
        int         live [$];
        logic [1:0] op_code;
        bit [7:0]   slot;
        bit [31:0]  gen;
        bit [15:0]  own;
        bit         priv;
        slot = 8'($urandom_range(0, 255));
        gen  = $urandom();
        own  = 16'($urandom_range(0, 65535));
        priv = 1'($urandom_range(0, 1));
        pick = int'($urandom_range(0, 99));
        if (pick < create_pct)
            op_code = ghp_pkg::OP_CREATE;
        else if (pick >= 96)
            op_code = OP_UNUSED;
        else
        begin
            op_code = $urandom_range(0, 1) ? ghp_pkg::OP_VIEW : ghp_pkg::OP_RELEASE;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (pool.occupied[i])
                    live.insert(live.size(), i);
            end
            kind = int'($urandom_range(0, 9));
            if (kind == 0)
                slot = 8'($urandom_range(SLOTS, 255));
            else
            begin
                // kind two: any slot with its current generation, often a free one
                if (live.size() > 0 && kind > 2)
                    slot = 8'(live[$urandom_range(0, live.size() - 1)]);
                else
                    slot = 8'($urandom_range(0, SLOTS - 1));
                gen = pool.generation[slot];
                // kind one: generation off by one either way
                if (kind == 1)
                    gen = gen + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            end
        end
        send_item(op_code, slot, gen, own, priv);
    endtask

    // result side with random stalls while gaps are paced
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = pace_gaps ? int'($urandom_range(0, 4)) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            pool.check_reply(m_axis_tuser, m_axis_tdata);
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // main sequence
    initial
    begin
        int create_pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // handles of a slot that was never created
        send_item(ghp_pkg::OP_VIEW, 8'd0, ghp_pkg::FIRST_GEN, 16'hFFFF, 1'b1);
        send_item(ghp_pkg::OP_RELEASE, 8'd0, ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);
        // creates with payload extremes, then view both
        send_item(ghp_pkg::OP_CREATE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(ghp_pkg::OP_CREATE, 8'd0, 32'd0, 16'h0000, 1'b0);
        send_item(ghp_pkg::OP_VIEW, 8'd0, ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);
        send_item(ghp_pkg::OP_VIEW, 8'd1, ghp_pkg::FIRST_GEN, 16'hFFFF, 1'b1);
        // slots beyond the pool and wrong generations
        send_item(ghp_pkg::OP_VIEW, 8'hFF, ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);
        send_item(ghp_pkg::OP_VIEW, 8'(SLOTS), ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);
        send_item(ghp_pkg::OP_RELEASE, 8'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        send_item(ghp_pkg::OP_VIEW, 8'd0, 32'd0, 16'h0000, 1'b0);
        // release, then the old handle is stale
        send_item(ghp_pkg::OP_RELEASE, 8'd0, ghp_pkg::FIRST_GEN, 16'hFFFF, 1'b1);
        send_item(ghp_pkg::OP_RELEASE, 8'd0, ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);
        send_item(ghp_pkg::OP_VIEW, 8'd0, ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);
        // slot zero comes back with the next generation
        send_item(ghp_pkg::OP_CREATE, 8'd0, 32'd0, 16'h5A5A, 1'b1);
        send_item(ghp_pkg::OP_VIEW, 8'd0, ghp_pkg::FIRST_GEN + 32'd1, 16'h0000, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // fill the pool, then one create too many
        for (int i = 0; i < SLOTS - 1; i++)
            send_item(ghp_pkg::OP_CREATE, 8'd0, 32'd0, 16'($urandom()), 1'($urandom()));
        send_item(ghp_pkg::OP_VIEW, 8'(SLOTS - 1), ghp_pkg::FIRST_GEN, 16'h0000, 1'b0);

        // random phases that fill, drain and churn the pool, some with no gaps
        for (int blk = 0; blk < RANDOM_ITEMS / 100; blk++)
        begin
            pace_gaps  = (blk % 4 != 2);
            create_pct = (blk % 3 == 0) ? 70 : (blk % 3 == 1) ? 20 : 45;
            repeat (100) random_item(create_pct);
        end
        s_axis_tvalid <= 1'b0;

        while (pool.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d creates, %0d on a full pool, %0d releases, %0d views",
                 pool.n_created, pool.n_full, pool.n_released, pool.n_viewed);
        $display("%0d stale or foreign handles, %0d unused opcodes, %0d results compared",
                 pool.n_rejected, pool.n_unused, pool.replies);
        if (pool.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ generational_handle_pool.f @@
+incdir+hdl
hdl/ghp_pkg.sv
hdl/ghp_ctrl.sv
hdl/ghp_datapath.sv
hdl/generational_handle_pool.sv
tb/tb_generational_handle_pool.sv
